// ----- rtl/sfrd_pkg.sv -----
// ----------------------------------------------------------------------------
// SBUS frame decoder package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package sfrd_pkg;

	// Frame layout
	localparam int FRAME_BYTES   = 25;
	localparam int POS_W         = $clog2(FRAME_BYTES + 1);
	localparam int FLAG_POS      = 23;
	localparam int DATA_BYTES    = 22;
	localparam int SLOT_W        = $clog2(DATA_BYTES);
	localparam int CHAN_W        = 11;
	localparam int ANALOG_CH     = 16;
	localparam int NUM_CH        = ANALOG_CH + 2;
	localparam int IDX_W         = 5;
	localparam int PAYLOAD_BITS  = DATA_BYTES * 8;

	localparam logic [7:0] START_BYTE = 8'h0F;

	// Configuration register map
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TIMEOUT    = 2'd0,
		CFG_DIGI_LOW   = 2'd1,
		CFG_DIGI_HIGH  = 2'd2
	} cfg_index_t;

	localparam logic [15:0]       TIMEOUT_RST   = 16'd3500;
	localparam logic [CHAN_W-1:0] DIGI_LOW_RST  = 11'd173;
	localparam logic [CHAN_W-1:0] DIGI_HIGH_RST = 11'd1812;

	// Frame status codes
	typedef enum logic [1:0] {
		ST_COMPLETE    = 2'd0,
		ST_FAILSAFE    = 2'd1,
		ST_SIGNAL_LOSS = 2'd2
	} frame_status_t;

	// Flag byte bits
	localparam int FLAG_DIGI0     = 0;
	localparam int FLAG_DIGI1     = 1;
	localparam int FLAG_LOST      = 2;
	localparam int FLAG_FAILSAFE  = 3;

	// Controller to datapath
	typedef struct packed {
		logic byte_take;   // input transfer this cycle
		logic emit_step;   // load next result into the output register
	} sfrd_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic frame_done;  // current input byte completes a frame
		logic chan_last;   // next result is the final one of the frame
	} sfrd_sts_t;

endpackage

// ----- rtl/sfrd_ctrl.sv -----
// ----------------------------------------------------------------------------
// SBUS frame decoder controller
// Sequences byte reception and the per-channel result emission.
// ----------------------------------------------------------------------------
module sfrd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output sfrd_pkg::sfrd_cmd_t  cmd,
	input  sfrd_pkg::sfrd_sts_t  sts
);

	typedef enum logic {
		S_RECV,
		S_EMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	// Handshake and commands
	always_comb begin
		in_ready       = (state_q == S_RECV);
		cmd.byte_take  = in_valid && (state_q == S_RECV);
		cmd.emit_step  = (state_q == S_EMIT) && (!out_valid_q || out_ready);
	end

	assign out_valid = out_valid_q;

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RECV;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit_step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_RECV: begin
					if (cmd.byte_take && sts.frame_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (cmd.emit_step && sts.chan_last) begin
						state_q <= S_RECV;
					end
				end
				default: begin
					state_q <= S_RECV;
				end
			endcase
		end
	end

endmodule

// ----- rtl/sfrd_dp.sv -----
// ----------------------------------------------------------------------------
// SBUS frame decoder datapath
// Position tracking, timeout check, frame storage, channel unpacking,
// configuration registers and the output register.
// ----------------------------------------------------------------------------
module sfrd_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sfrd_pkg::sfrd_cmd_t                cmd,
	output sfrd_pkg::sfrd_sts_t                sts,
	input  logic [7:0]                         rx_byte,
	input  logic [31:0]                        now_us,
	input  logic                               cfg_we,
	input  logic [sfrd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sfrd_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic [sfrd_pkg::IDX_W-1:0]         channel_index,
	output logic [sfrd_pkg::CHAN_W-1:0]        channel_value,
	output logic [1:0]                         frame_status,
	output logic                               last_of_frame
);

	logic [15:0]                      timeout_q;
	logic [sfrd_pkg::CHAN_W-1:0]      digi_low_q;
	logic [sfrd_pkg::CHAN_W-1:0]      digi_high_q;

	logic [sfrd_pkg::POS_W-1:0]       pos_q;
	logic [31:0]                      start_q;
	logic [sfrd_pkg::DATA_BYTES-1:0][7:0] payload_q;
	logic [7:0]                       flags_q;
	logic [sfrd_pkg::IDX_W-1:0]       chan_q;

	logic [sfrd_pkg::IDX_W-1:0]       idx_q;
	logic [sfrd_pkg::CHAN_W-1:0]      value_q;
	logic [1:0]                       status_q;
	logic                             last_q;

	logic [31:0]                      diff;
	logic                             timed_out;
	logic [sfrd_pkg::POS_W-1:0]       pos_eff;
	logic                             is_start;
	logic                             stored;
	logic [sfrd_pkg::POS_W-1:0]       pos_m1;
	logic [sfrd_pkg::SLOT_W-1:0]      slot;
	logic                             in_data;
	logic [sfrd_pkg::PAYLOAD_BITS-1:0] payload_flat;
	logic [sfrd_pkg::CHAN_W-1:0]      next_value;
	sfrd_pkg::frame_status_t          next_status;

	// Timeout on signed wrapped gap, then effective position
	always_comb begin
		diff      = now_us - start_q;
		timed_out = !diff[31] && (diff[30:0] > 31'(timeout_q));
		pos_eff   = timed_out ? '0 : pos_q;
		is_start  = (rx_byte == sfrd_pkg::START_BYTE);
		stored    = (pos_eff == '0) ? is_start
		          : (pos_eff < sfrd_pkg::POS_W'(sfrd_pkg::FRAME_BYTES));
		pos_m1    = pos_eff - sfrd_pkg::POS_W'(1);
		slot      = pos_m1[sfrd_pkg::SLOT_W-1:0];
		in_data   = (pos_eff != '0)
		          && (pos_eff <= sfrd_pkg::POS_W'(sfrd_pkg::DATA_BYTES));
	end

	assign sts.frame_done = (pos_eff == sfrd_pkg::POS_W'(sfrd_pkg::FRAME_BYTES - 1));
	assign sts.chan_last  = (chan_q == sfrd_pkg::IDX_W'(sfrd_pkg::NUM_CH - 1));

	// Next result: analog from the shifting payload, digital from flag bits
	assign payload_flat = payload_q;
	always_comb begin
		if (chan_q < sfrd_pkg::IDX_W'(sfrd_pkg::ANALOG_CH)) begin
			next_value = payload_flat[sfrd_pkg::CHAN_W-1:0];
		end else if (chan_q == sfrd_pkg::IDX_W'(sfrd_pkg::ANALOG_CH)) begin
			next_value = flags_q[sfrd_pkg::FLAG_DIGI0] ? digi_high_q : digi_low_q;
		end else begin
			next_value = flags_q[sfrd_pkg::FLAG_DIGI1] ? digi_high_q : digi_low_q;
		end
		if (flags_q[sfrd_pkg::FLAG_FAILSAFE]) begin
			next_status = sfrd_pkg::ST_FAILSAFE;
		end else if (flags_q[sfrd_pkg::FLAG_LOST]) begin
			next_status = sfrd_pkg::ST_SIGNAL_LOSS;
		end else begin
			next_status = sfrd_pkg::ST_COMPLETE;
		end
	end

	// Control state: config, position, start time, channel counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= sfrd_pkg::TIMEOUT_RST;
			digi_low_q  <= sfrd_pkg::DIGI_LOW_RST;
			digi_high_q <= sfrd_pkg::DIGI_HIGH_RST;
			pos_q       <= '0;
			start_q     <= '0;
			chan_q      <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					sfrd_pkg::CFG_TIMEOUT:   timeout_q   <= cfg_data;
					sfrd_pkg::CFG_DIGI_LOW:  digi_low_q  <= cfg_data[sfrd_pkg::CHAN_W-1:0];
					sfrd_pkg::CFG_DIGI_HIGH: digi_high_q <= cfg_data[sfrd_pkg::CHAN_W-1:0];
					default: ;
				endcase
			end
			if (cmd.byte_take) begin
				if ((pos_eff == '0) && is_start) begin
					start_q <= now_us;
				end
				pos_q <= stored ? pos_eff + sfrd_pkg::POS_W'(1) : pos_eff;
				if (sts.frame_done) begin
					chan_q <= '0;
				end
			end
			if (cmd.emit_step) begin
				chan_q <= chan_q + sfrd_pkg::IDX_W'(1);
			end
		end
	end

	// Frame storage and output register (no reset needed)
	always_ff @(posedge clk) begin
		if (cmd.byte_take && stored) begin
			if (in_data) begin
				payload_q[slot] <= rx_byte;
			end
			if (pos_eff == sfrd_pkg::POS_W'(sfrd_pkg::FLAG_POS)) begin
				flags_q <= rx_byte;
			end
		end
		if (cmd.emit_step) begin
			if (chan_q < sfrd_pkg::IDX_W'(sfrd_pkg::ANALOG_CH)) begin
				payload_q <= payload_flat >> sfrd_pkg::CHAN_W;
			end
			idx_q    <= chan_q;
			value_q  <= next_value;
			status_q <= next_status;
			last_q   <= sts.chan_last;
		end
	end

	assign channel_index = idx_q;
	assign channel_value = value_q;
	assign frame_status  = status_q;
	assign last_of_frame = last_q;

endmodule

// ----- rtl/sbus_frame_receiver_decoder.sv -----
// ----------------------------------------------------------------------------
// SBUS frame receiver and channel decoder
// A new input byte can be taken every clock while in_ready is high. The byte
// that completes a 25-byte frame is followed by 18 results, one per channel
// (16 analog, 2 digital), paced by the single output register: in_ready is
// low until the last one is loaded, output stalls included. Results leave in
// channel order with the frame status on each and last_of_frame on channel
// 17. No clearing pass after reset; configuration writes are always taken.
// ----------------------------------------------------------------------------
module sbus_frame_receiver_decoder (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [7:0]                         rx_byte,
	input  logic [31:0]                        now_us,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [sfrd_pkg::IDX_W-1:0]         channel_index,
	output logic [sfrd_pkg::CHAN_W-1:0]        channel_value,
	output logic [1:0]                         frame_status,
	output logic                               last_of_frame,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [sfrd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sfrd_pkg::CFG_DATA_W-1:0]    cfg_data
);

	sfrd_pkg::sfrd_cmd_t cmd;
	sfrd_pkg::sfrd_sts_t sts;

	// Configuration writes never stall
	assign cfg_ready = 1'b1;

	sfrd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	sfrd_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.rx_byte       (rx_byte),
		.now_us        (now_us),
		.cfg_we        (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.channel_index (channel_index),
		.channel_value (channel_value),
		.frame_status  (frame_status),
		.last_of_frame (last_of_frame)
	);

endmodule

// ----- rtl/sfrd_chk.sv -----
// ----------------------------------------------------------------------------
// SBUS frame decoder port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module sfrd_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [sfrd_pkg::IDX_W-1:0]     channel_index,
	input logic [sfrd_pkg::CHAN_W-1:0]    channel_value,
	input logic                           last_of_frame
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(channel_index)
		&& $stable(channel_value))
		else $error("output changed while stalled");

	// Last flag marks exactly the final channel
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_of_frame == (channel_index == sfrd_pkg::IDX_W'(sfrd_pkg::NUM_CH - 1))))
		else $error("last_of_frame does not match channel 17");

	// Channel index within range
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> channel_index < sfrd_pkg::IDX_W'(sfrd_pkg::NUM_CH))
		else $error("channel index out of range");

	// No byte taken while a frame is still being emitted
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_frame |-> !in_ready)
		else $error("input ready during frame emission");

endmodule

bind sbus_frame_receiver_decoder sfrd_chk u_sfrd_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.channel_index (channel_index),
	.channel_value (channel_value),
	.last_of_frame (last_of_frame)
);

// ----- sim/sbus_frame_receiver_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// SBUS frame receiver and decoder testbench
// Sends timestamped serial bytes through the valid/ready input channel while
// a scoreboard predicts framing, timeouts and channel unpacking. Every channel
// result is compared field by field with the prediction. Configuration is
// changed between phases while the block is idle. Both sides idle at random,
// except in one phase.
module sbus_frame_receiver_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT = 100000;
	localparam logic [sfrd_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct {
		logic [sfrd_pkg::IDX_W-1:0]  chan;
		logic [sfrd_pkg::CHAN_W-1:0] value;
		sfrd_pkg::frame_status_t     status;
		logic                        last;
	} chan_result_t;

	// Frame tracker and queue of channel results still due
	class frame_scoreboard;
		logic [15:0]                 timeout   = sfrd_pkg::TIMEOUT_RST;
		logic [sfrd_pkg::CHAN_W-1:0] digi_low  = sfrd_pkg::DIGI_LOW_RST;
		logic [sfrd_pkg::CHAN_W-1:0] digi_high = sfrd_pkg::DIGI_HIGH_RST;
		logic [sfrd_pkg::POS_W-1:0]  pos       = '0;
		logic [31:0]                 start_time = '0;
		logic [7:0]                  store [sfrd_pkg::FRAME_BYTES];
		chan_result_t                due_channels [$];
		int                          errors = 0;
		int                          stored = 0;

		function void write_reg(logic [sfrd_pkg::CFG_IDX_W-1:0] idx,
				logic [sfrd_pkg::CFG_DATA_W-1:0] d);
			case (idx)
				sfrd_pkg::CFG_TIMEOUT:   timeout   = d;
				sfrd_pkg::CFG_DIGI_LOW:  digi_low  = d[sfrd_pkg::CHAN_W-1:0];
				sfrd_pkg::CFG_DIGI_HIGH: digi_high = d[sfrd_pkg::CHAN_W-1:0];
				default: ;
			endcase
		endfunction

		// Returns 1 when the byte was stored in the frame
		function bit take_byte(logic [7:0] b, logic [31:0] t);
			logic [31:0]                       gap;
			logic [sfrd_pkg::PAYLOAD_BITS-1:0] bits;
			logic [7:0]                        flags;
			sfrd_pkg::frame_status_t           st;
			chan_result_t                      r;
			int                                k;
			gap = t - start_time;
			// a gap with bit 31 set is a negative time and never times out
			if (!gap[31] && gap > {16'd0, timeout})
				pos = '0;
			if (pos == 0) begin
				if (b != sfrd_pkg::START_BYTE)
					return 1'b0;
				start_time = t;
			end
			if (pos >= sfrd_pkg::FRAME_BYTES)
				return 1'b0;
			store[pos] = b;
			pos++;
			stored++;
			if (pos < sfrd_pkg::FRAME_BYTES)
				return 1'b1;

			// frame complete: unpack sixteen channels LSB first, then digitals
			for (k = 0; k < sfrd_pkg::DATA_BYTES; k++)
				bits[k*8 +: 8] = store[k+1];
			flags = store[sfrd_pkg::FLAG_POS];
			st = flags[sfrd_pkg::FLAG_FAILSAFE] ? sfrd_pkg::ST_FAILSAFE :
				flags[sfrd_pkg::FLAG_LOST] ? sfrd_pkg::ST_SIGNAL_LOSS :
				sfrd_pkg::ST_COMPLETE;
			r.status = st;
			r.last   = 1'b0;
			for (k = 0; k < sfrd_pkg::ANALOG_CH; k++) begin
				r.chan  = k[sfrd_pkg::IDX_W-1:0];
				r.value = bits[k*sfrd_pkg::CHAN_W +: sfrd_pkg::CHAN_W];
				due_channels.push_back(r);
			end
			r.chan  = sfrd_pkg::IDX_W'(sfrd_pkg::ANALOG_CH);
			r.value = flags[sfrd_pkg::FLAG_DIGI0] ? digi_high : digi_low;
			due_channels.push_back(r);
			r.chan  = sfrd_pkg::IDX_W'(sfrd_pkg::ANALOG_CH + 1);
			r.value = flags[sfrd_pkg::FLAG_DIGI1] ? digi_high : digi_low;
			r.last  = 1'b1;
			due_channels.push_back(r);
			return 1'b1;
		endfunction

		function void match_channel(logic [sfrd_pkg::IDX_W-1:0] ch,
				logic [sfrd_pkg::CHAN_W-1:0] v, logic [1:0] st, logic lst);
			chan_result_t e;
			if (due_channels.size() == 0) begin
				errors++;
				$display("%0t: channel %0d value %0d arrived with nothing due", $time, ch, v);
				return;
			end
			e = due_channels.pop_front();
			if (ch !== e.chan) begin
				errors++;
				$display("%0t: channel_index expected %0d got %0d", $time, e.chan, ch);
			end
			if (v !== e.value) begin
				errors++;
				$display("%0t: channel_value (ch %0d) expected %0d got %0d",
					$time, e.chan, e.value, v);
			end
			if (st !== e.status) begin
				errors++;
				$display("%0t: frame_status (ch %0d) expected %0d got %0d",
					$time, e.chan, e.status, st);
			end
			if (lst !== e.last) begin
				errors++;
				$display("%0t: last_of_frame (ch %0d) expected %0b got %0b",
					$time, e.chan, e.last, lst);
			end
		endfunction

		function int pending();
			return due_channels.size();
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic [7:0]                      rx_byte = '0;
	logic [31:0]                     now_us = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic [sfrd_pkg::IDX_W-1:0]      channel_index;
	logic [sfrd_pkg::CHAN_W-1:0]     channel_value;
	logic [1:0]                      frame_status;
	logic                            last_of_frame;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [sfrd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [sfrd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	frame_scoreboard sb;
	bit              no_gaps = 1'b0;
	int              cycles = 0;
	logic [31:0]     t_now = '0;
	logic [31:0]     frame_t0 = '0;
	logic [15:0]     cur_timeout = sfrd_pkg::TIMEOUT_RST;

	sbus_frame_receiver_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.now_us(now_us),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.channel_index(channel_index),
		.channel_value(channel_value),
		.frame_status(frame_status),
		.last_of_frame(last_of_frame),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("sbus_frame_receiver_decoder_tb: errors");
			$finish;
		end
	end

	// Consumer stalls
	always @(negedge clk) begin
		out_ready <= no_gaps || ($urandom_range(99) >= 21);
	end

	// Transfer monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				void'(sb.take_byte(rx_byte, now_us));
			if (out_valid && out_ready)
				sb.match_channel(channel_index, channel_value, frame_status, last_of_frame);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic [31:0] t);
		@(negedge clk);
		while (!no_gaps && $urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		now_us   <= t;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic cfg_write(input logic [sfrd_pkg::CFG_IDX_W-1:0] idx,
			input logic [sfrd_pkg::CFG_DATA_W-1:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Idle the input and let every due result drain
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Frame of len bytes starting after the timeout has lapsed
	task automatic send_frame(input int len);
		logic [31:0] t;
		logic [31:0] step;
		logic [7:0]  b;
		int          i;
		frame_t0 = t_now + cur_timeout + 1 + $urandom_range(4000);
		step = cur_timeout / 26;
		for (i = 0; i < len; i++) begin
			if (i == 0)
				b = sfrd_pkg::START_BYTE;
			else if (i >= sfrd_pkg::FLAG_POS)
				b = 8'($urandom_range(255));
			else begin
				case ($urandom_range(3))
					0: b = 8'h00;
					1: b = 8'hFF;
					default: b = 8'($urandom_range(255));
				endcase
			end
			t = frame_t0 + i * step;
			// last byte exactly on the timeout, or a byte stamped before the start
			if (i == sfrd_pkg::FRAME_BYTES - 1 && $urandom_range(3) == 0)
				t = frame_t0 + cur_timeout;
			else if (i > 0 && $urandom_range(19) == 0)
				t = frame_t0 - $urandom_range(1, 100000);
			send_byte(b, t);
		end
		t_now = frame_t0 + cur_timeout;
	endtask

	task automatic run_chunk(input int quota);
		int goal;
		int n;
		int i;
		int kind;
		goal = sb.stored + quota;
		while (sb.stored < goal) begin
			kind = $urandom_range(99);
			if (kind < 70) begin
				send_frame(sfrd_pkg::FRAME_BYTES);
				// bytes after a full frame, inside the timeout: ignored
				if ($urandom_range(2) == 0) begin
					n = $urandom_range(1, 3);
					for (i = 0; i < n; i++)
						send_byte(8'($urandom_range(255)),
							frame_t0 + $urandom_range(cur_timeout));
				end
			end else if (kind < 85) begin
				// cut short, then one byte just past the timeout
				send_frame($urandom_range(1, sfrd_pkg::FRAME_BYTES - 1));
				send_byte($urandom_range(1) ? sfrd_pkg::START_BYTE : 8'($urandom_range(255)),
					frame_t0 + cur_timeout + 1);
			end else begin
				n = $urandom_range(1, 6);
				for (i = 0; i < n; i++)
					send_byte($urandom_range(3) == 0 ? sfrd_pkg::START_BYTE
						: 8'($urandom_range(255)), $urandom());
			end
		end
	endtask

	task automatic set_phase(input int p);
		logic [15:0] tmo;
		case (p)
			1: begin
				tmo = 16'd0;
				cfg_write(sfrd_pkg::CFG_TIMEOUT, tmo);
				cfg_write(sfrd_pkg::CFG_DIGI_LOW, 16'h0000);
				cfg_write(sfrd_pkg::CFG_DIGI_HIGH, 16'hFFFF);
				cfg_write(CFG_SPARE, 16'($urandom()));
			end
			2: begin
				tmo = 16'hFFFF;
				cfg_write(sfrd_pkg::CFG_DIGI_HIGH, 16'h0000);
				cfg_write(sfrd_pkg::CFG_TIMEOUT, tmo);
				cfg_write(sfrd_pkg::CFG_DIGI_LOW, 16'h07FF);
			end
			3: begin
				tmo = 16'($urandom_range(65535));
				cfg_write(sfrd_pkg::CFG_TIMEOUT, tmo);
				cfg_write(sfrd_pkg::CFG_DIGI_LOW, 16'($urandom()));
				cfg_write(sfrd_pkg::CFG_DIGI_HIGH, 16'($urandom()));
				cfg_write(CFG_SPARE, 16'($urandom()));
			end
			default: begin
				tmo = sfrd_pkg::TIMEOUT_RST;
				cfg_write(sfrd_pkg::CFG_TIMEOUT, tmo);
				cfg_write(sfrd_pkg::CFG_DIGI_LOW, {5'd0, sfrd_pkg::DIGI_LOW_RST});
				cfg_write(sfrd_pkg::CFG_DIGI_HIGH, {5'd0, sfrd_pkg::DIGI_HIGH_RST});
			end
		endcase
		cur_timeout = tmo;
		// one phase runs with neither side idling
		no_gaps = (p == 2);
	endtask

	initial begin
		int i;
		int p;
		sb = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// wrong start bytes at position zero
		send_byte(8'h00, 32'd10);
		send_byte(8'hFF, 32'd20);
		// all-ones frame across the timestamp wrap, failsafe and lost both set
		frame_t0 = 32'hFFFF_FF00;
		send_byte(sfrd_pkg::START_BYTE, frame_t0);
		for (i = 1; i < sfrd_pkg::FLAG_POS; i++)
			send_byte(8'hFF, frame_t0 + i * 100);
		send_byte(8'h0F, frame_t0 + sfrd_pkg::FLAG_POS * 100);
		send_byte(8'hFF, frame_t0 + (sfrd_pkg::FRAME_BYTES - 1) * 100);
		// start byte after a full frame, still inside the timeout
		send_byte(sfrd_pkg::START_BYTE, frame_t0 + 3000);
		t_now = frame_t0 + cur_timeout;
		settle();

		run_chunk(70);
		settle();
		for (p = 1; p <= 4; p++) begin
			set_phase(p);
			run_chunk(70);
			settle();
		end
		no_gaps = 1'b0;

		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("sbus_frame_receiver_decoder_tb: clean");
		else
			$display("sbus_frame_receiver_decoder_tb: errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/sfrd_pkg.sv
rtl/sfrd_ctrl.sv
rtl/sfrd_dp.sv
rtl/sbus_frame_receiver_decoder.sv
rtl/sfrd_chk.sv
sim/sbus_frame_receiver_decoder_tb.sv
